// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define TI2D_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define TI2D_ASSERT_NEXT(lbl, clk, rstn, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (nxt)) else $error(msg);

`endif

// ===== hdl/ti2d_pkg.sv =====
// ----------------------------------------------------------------------------
// ti2d_pkg
// Types, constants and the arctangent table of the planar twist integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ti2d_pkg;

	localparam int WORD_W            = 24;
	localparam int ANG_BITS          = 30;
	localparam int FRAC_BITS_DEF     = 16;
	localparam int CORDIC_STAGES_DEF = 18;

	localparam logic [33:0] PI_Q30      = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
	localparam logic [31:0] GAIN_Q30    = 32'h26DD3B6A;

	typedef struct packed {
		logic signed [WORD_W-1:0] angular_rate;
		logic signed [WORD_W-1:0] rate_x;
		logic signed [WORD_W-1:0] rate_y;
	} twist_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pose_x;
		logic signed [WORD_W-1:0] pose_y;
		logic signed [WORD_W-1:0] pose_angle;
		logic                     saturated;
	} pose_t;

	// Twist traveling with its angle; flip is the sign of the angle during
	// reduction and the half-turn fold mark afterwards.
	typedef struct packed {
		twist_t twist;
		logic   flip;
	} meta_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic over_x;
		logic over_y;
	} div_flag_t;

	function automatic logic [31:0] atan_q30(input int i);
		logic [31:0] v;
		unique case (i)
			0:  v = 32'h3243F6A8;
			1:  v = 32'h1DAC6705;
			2:  v = 32'h0FADBAFC;
			3:  v = 32'h07F56EA6;
			4:  v = 32'h03FEAB76;
			5:  v = 32'h01FFD55B;
			6:  v = 32'h00FFFAAA;
			7:  v = 32'h007FFF55;
			8:  v = 32'h003FFFEA;
			9:  v = 32'h001FFFFD;
			10: v = 32'h000FFFFF;
			11: v = 32'h0007FFFF;
			12: v = 32'h0003FFFF;
			13: v = 32'h0001FFFF;
			14: v = 32'h0000FFFF;
			15: v = 32'h00007FFF;
			16: v = 32'h00003FFF;
			17: v = 32'h00001FFF;
			18: v = 32'h00000FFF;
			19: v = 32'h000007FF;
			20: v = 32'h000003FF;
			21: v = 32'h000001FF;
			22: v = 32'h000000FF;
			23: v = 32'h0000007F;
			24: v = 32'h0000003F;
			25: v = 32'h0000001F;
			26: v = 32'h0000000F;
			27: v = 32'h00000008;
			28: v = 32'h00000004;
			29: v = 32'h00000002;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ti2d_red_cell.sv =====
// ----------------------------------------------------------------------------
// ti2d_red_cell
// One step of the angle reduction: subtract 2*pi*2^K when it fits.
// ----------------------------------------------------------------------------
`default_nettype none

module ti2d_red_cell #(
	parameter int W = 38,
	parameter int K = 0
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic            in_valid,
	input  ti2d_pkg::meta_t      in_meta,
	input  wire logic [W-1:0]    in_mag,
	output logic                 out_valid,
	output ti2d_pkg::meta_t      out_meta,
	output logic [W-1:0]         out_mag
);

	localparam logic [W+33:0] LIM = (W+34)'(ti2d_pkg::TWO_PI_Q30) << K;

	logic [W+33:0] ext;
	logic [W-1:0]  mag_n;

	always_comb begin
		ext   = (W+34)'(in_mag);
		mag_n = (ext >= LIM) ? W'(ext - LIM) : in_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_meta <= in_meta;
			out_mag  <= mag_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ti2d_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ti2d_cordic_cell
// One rotation-mode CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ti2d_cordic_cell #(
	parameter int CW = 34,
	parameter int AW = 35,
	parameter int I  = 0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic                 in_valid,
	input  ti2d_pkg::meta_t           in_meta,
	input  wire logic signed [CW-1:0] in_x,
	input  wire logic signed [CW-1:0] in_y,
	input  wire logic signed [AW-1:0] in_z,
	output logic                      out_valid,
	output ti2d_pkg::meta_t           out_meta,
	output logic signed [CW-1:0]      out_x,
	output logic signed [CW-1:0]      out_y,
	output logic signed [AW-1:0]      out_z
);

	localparam logic signed [AW-1:0] ATAN = $signed(AW'(ti2d_pkg::atan_q30(I)));

	logic signed [CW-1:0] xs, ys, x_n, y_n;
	logic signed [AW-1:0] z_n;

	always_comb begin
		xs = in_x >>> I;
		ys = in_y >>> I;
		if (!in_z[AW-1]) begin
			x_n = in_x - ys;
			y_n = in_y + xs;
			z_n = in_z - ATAN;
		end else begin
			x_n = in_x + ys;
			y_n = in_y - xs;
			z_n = in_z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_meta <= in_meta;
			out_x    <= x_n;
			out_y    <= y_n;
			out_z    <= z_n;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ti2d_div_cell.sv =====
// ----------------------------------------------------------------------------
// ti2d_div_cell
// One restoring-division step for both translation lanes: quotient bit K.
// ----------------------------------------------------------------------------
`default_nettype none

module ti2d_div_cell #(
	parameter int RW = 62,
	parameter int ZW = 38,
	parameter int QB = 24,
	parameter int K  = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             in_valid,
	input  ti2d_pkg::meta_t       in_meta,
	input  ti2d_pkg::div_flag_t   in_flags,
	input  wire logic [ZW-1:0]    in_ud,
	input  wire logic [RW-1:0]    in_rem_x,
	input  wire logic [RW-1:0]    in_rem_y,
	input  wire logic [QB-1:0]    in_q_x,
	input  wire logic [QB-1:0]    in_q_y,
	output logic                  out_valid,
	output ti2d_pkg::meta_t       out_meta,
	output ti2d_pkg::div_flag_t   out_flags,
	output logic [ZW-1:0]         out_ud,
	output logic [RW-1:0]         out_rem_x,
	output logic [RW-1:0]         out_rem_y,
	output logic [QB-1:0]         out_q_x,
	output logic [QB-1:0]         out_q_y
);

	logic [RW-1:0] lim, rem_x_n, rem_y_n;
	logic          ge_x, ge_y;

	always_comb begin
		lim     = RW'(in_ud) << K;
		ge_x    = in_rem_x >= lim;
		ge_y    = in_rem_y >= lim;
		rem_x_n = ge_x ? in_rem_x - lim : in_rem_x;
		rem_y_n = ge_y ? in_rem_y - lim : in_rem_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_meta  <= in_meta;
			out_flags <= in_flags;
			out_ud    <= in_ud;
			out_rem_x <= rem_x_n;
			out_rem_y <= rem_y_n;
			out_q_x   <= in_q_x | (QB'(ge_x) << K);
			out_q_y   <= in_q_y | (QB'(ge_y) << K);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/twist_integrate_2d_core.sv =====
// ----------------------------------------------------------------------------
// twist_integrate_2d_core
// Exponential map of a planar twist: rotation equals the angular rate, the
// translation follows from CORDIC sine/cosine and a rounded division.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  twist   | twist_valid / twist_stall  | ti2d_pkg::twist_t (w, vx, vy)
//  pose    | pose_valid  / pose_stall   | ti2d_pkg::pose_t  (x, y, angle, sat)
//
//  One twist enters per cycle while twist_stall is low; it passes s1, a row of
//  RED = max(22 - FRAC_BITS, 1) reduction cells, s2, the CORDIC row, s3 to s7,
//  the division row (one cell per result bit) and the output register.
//  Reset clears every valid bit; payload registers are not reset.
//  A stalled result freezes the whole row of cells; twist_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module twist_integrate_2d_core #(
	parameter int FRAC_BITS     = ti2d_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STAGES = ti2d_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        twist_valid,
	output logic             twist_stall,
	input  ti2d_pkg::twist_t twist,
	output logic             pose_valid,
	input  wire logic        pose_stall,
	output ti2d_pkg::pose_t  pose
);

	localparam int WW    = ti2d_pkg::WORD_W;
	localparam int SHIFT = ti2d_pkg::ANG_BITS - FRAC_BITS;
	localparam int ZW    = WW + SHIFT;
	localparam int RED   = (ZW > 33) ? ZW - 32 : 1;
	localparam int AW    = 35;
	localparam int CW    = 34;
	localparam int QB    = WW;
	localparam int PW    = WW + CW;
	localparam int NW    = PW + 1;
	localparam int UW    = NW + 1;
	localparam int RW    = ZW + QB;
	localparam int CMPW  = ((UW > RW) ? UW : RW) + 1;

	localparam logic signed [AW-1:0] PI_S   = $signed(AW'(ti2d_pkg::PI_Q30));
	localparam logic signed [AW-1:0] HALF_S = $signed(AW'(ti2d_pkg::HALF_PI_Q30));
	localparam logic signed [AW-1:0] TWO_S  = $signed(AW'(ti2d_pkg::TWO_PI_Q30));
	localparam logic signed [CW-1:0] ONE_C  = $signed(CW'(1) << ti2d_pkg::ANG_BITS);
	localparam logic signed [CW-1:0] GAIN_C = $signed(CW'(ti2d_pkg::GAIN_Q30));
	localparam logic [WW-1:0]        OUT_MAX = {1'b0, {(WW-1){1'b1}}};
	localparam logic [WW-1:0]        OUT_MIN = {1'b1, {(WW-1){1'b0}}};

	function automatic logic [ZW-1:0] mag_of(input logic signed [WW-1:0] w);
		logic [WW-1:0] a;
		a = w[WW-1] ? WW'(-w) : WW'(w);
		return ZW'(a) << SHIFT;
	endfunction

	// {saturated, value} of one lane from quotient magnitude and sign
	function automatic logic [WW:0] lane_result(input logic [QB-1:0] q, input logic neg,
			input logic over);
		logic [WW-1:0] v;
		logic          s;
		if (over || (!neg && q[QB-1]) || (neg && q[QB-1] && (q[QB-2:0] != '0))) begin
			s = 1'b1;
			v = neg ? OUT_MIN : OUT_MAX;
		end else begin
			s = 1'b0;
			v = neg ? WW'(-q) : WW'(q);
		end
		return {s, v};
	endfunction

	logic adv;
	assign adv         = !(pose_valid && pose_stall);
	assign twist_stall = !adv;

	// ---- s1: capture and take the angle magnitude
	logic            valid_s1;
	ti2d_pkg::meta_t meta_s1;
	logic [ZW-1:0]   mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= twist_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1.twist <= twist;
			meta_s1.flip  <= twist.angular_rate[WW-1];
			mag_s1        <= mag_of(twist.angular_rate);
		end
	end

	// ---- reduction row
	logic            red_valid [0:RED];
	ti2d_pkg::meta_t red_meta  [0:RED];
	logic [ZW-1:0]   red_mag   [0:RED];

	assign red_valid[0] = valid_s1;
	assign red_meta[0]  = meta_s1;
	assign red_mag[0]   = mag_s1;

	for (genvar i = 0; i < RED; i++) begin : g_red
		ti2d_red_cell #(.W(ZW), .K(RED - 1 - i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (red_valid[i]),
			.in_meta   (red_meta[i]),
			.in_mag    (red_mag[i]),
			.out_valid (red_valid[i+1]),
			.out_meta  (red_meta[i+1]),
			.out_mag   (red_mag[i+1])
		);
	end

	// ---- s2: restore sign, fold into [-pi/2, pi/2]
	logic signed [AW-1:0] r_c;
	logic                 fl_c;
	ti2d_pkg::meta_t      meta2_c;

	always_comb begin
		r_c = $signed(AW'(red_mag[RED]));
		if (red_meta[RED].flip) begin
			r_c = -r_c;
		end
		if (r_c > PI_S) begin
			r_c = r_c - TWO_S;
		end
		if (r_c < -PI_S) begin
			r_c = r_c + TWO_S;
		end
		priority if (r_c > HALF_S) begin
			r_c  = r_c - PI_S;
			fl_c = 1'b1;
		end else if (r_c < -HALF_S) begin
			r_c  = r_c + PI_S;
			fl_c = 1'b1;
		end else begin
			fl_c = 1'b0;
		end
		meta2_c      = red_meta[RED];
		meta2_c.flip = fl_c;
	end

	logic                 valid_s2;
	ti2d_pkg::meta_t      meta_s2;
	logic signed [AW-1:0] z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= red_valid[RED];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s2 <= meta2_c;
			z_s2    <= r_c;
		end
	end

	// ---- CORDIC row
	logic                 cor_valid [0:CORDIC_STAGES];
	ti2d_pkg::meta_t      cor_meta  [0:CORDIC_STAGES];
	logic signed [CW-1:0] cor_x     [0:CORDIC_STAGES];
	logic signed [CW-1:0] cor_y     [0:CORDIC_STAGES];
	logic signed [AW-1:0] cor_z     [0:CORDIC_STAGES];

	assign cor_valid[0] = valid_s2;
	assign cor_meta[0]  = meta_s2;
	assign cor_x[0]     = GAIN_C;
	assign cor_y[0]     = '0;
	assign cor_z[0]     = z_s2;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
		ti2d_cordic_cell #(.CW(CW), .AW(AW), .I(i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (cor_valid[i]),
			.in_meta   (cor_meta[i]),
			.in_x      (cor_x[i]),
			.in_y      (cor_y[i]),
			.in_z      (cor_z[i]),
			.out_valid (cor_valid[i+1]),
			.out_meta  (cor_meta[i+1]),
			.out_x     (cor_x[i+1]),
			.out_y     (cor_y[i+1]),
			.out_z     (cor_z[i+1])
		);
	end

	// ---- s3: undo the half-turn fold
	logic                 valid_s3;
	ti2d_pkg::meta_t      meta_s3;
	logic signed [CW-1:0] sin_s3, cos_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= cor_valid[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3 <= cor_meta[CORDIC_STAGES];
			sin_s3  <= cor_meta[CORDIC_STAGES].flip ? -cor_y[CORDIC_STAGES]
				: cor_y[CORDIC_STAGES];
			cos_s3  <= cor_meta[CORDIC_STAGES].flip ? -cor_x[CORDIC_STAGES]
				: cor_x[CORDIC_STAGES];
		end
	end

	// ---- s4: four products
	logic                 valid_s4;
	ti2d_pkg::meta_t      meta_s4;
	logic signed [PW-1:0] xs_s4, yc_s4, xc_s4, ys_s4;
	logic signed [CW-1:0] cm1_c, omc_c;

	assign cm1_c = cos_s3 - ONE_C;
	assign omc_c = ONE_C - cos_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s4 <= meta_s3;
			xs_s4   <= meta_s3.twist.rate_x * sin_s3;
			yc_s4   <= meta_s3.twist.rate_y * cm1_c;
			xc_s4   <= meta_s3.twist.rate_x * omc_c;
			ys_s4   <= meta_s3.twist.rate_y * sin_s3;
		end
	end

	// ---- s5: numerators
	logic                 valid_s5;
	ti2d_pkg::meta_t      meta_s5;
	logic signed [NW-1:0] nx_s5, ny_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s5 <= meta_s4;
			nx_s5   <= NW'(xs_s4) + NW'(yc_s4);
			ny_s5   <= NW'(xc_s4) + NW'(ys_s4);
		end
	end

	// ---- s6: magnitudes plus half divisor for round-to-nearest
	logic            valid_s6;
	ti2d_pkg::meta_t meta_s6;
	logic [UW-1:0]   un_x_s6, un_y_s6;
	logic [ZW-1:0]   ud_s6;
	logic            neg_x_s6, neg_y_s6;
	logic [ZW-1:0]   ud_c;
	logic [NW-1:0]   ax_c, ay_c;

	always_comb begin
		ud_c = mag_of(meta_s5.twist.angular_rate);
		ax_c = nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
		ay_c = ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s6  <= meta_s5;
			ud_s6    <= ud_c;
			un_x_s6  <= UW'(ax_c) + UW'(ud_c >> 1);
			un_y_s6  <= UW'(ay_c) + UW'(ud_c >> 1);
			neg_x_s6 <= nx_s5[NW-1] ^ meta_s5.twist.angular_rate[WW-1];
			neg_y_s6 <= ny_s5[NW-1] ^ meta_s5.twist.angular_rate[WW-1];
		end
	end

	// ---- s7: quotients too wide for the result saturate outright
	logic                 valid_s7;
	ti2d_pkg::meta_t      meta_s7;
	ti2d_pkg::div_flag_t  flags_s7;
	logic [ZW-1:0]        ud_s7;
	logic [RW-1:0]        rem_x_s7, rem_y_s7;
	logic [CMPW-1:0]      top_c;

	assign top_c = CMPW'(ud_s6) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s7         <= meta_s6;
			ud_s7           <= ud_s6;
			rem_x_s7        <= RW'(un_x_s6);
			rem_y_s7        <= RW'(un_y_s6);
			flags_s7.neg_x  <= neg_x_s6;
			flags_s7.neg_y  <= neg_y_s6;
			flags_s7.over_x <= CMPW'(un_x_s6) >= top_c;
			flags_s7.over_y <= CMPW'(un_y_s6) >= top_c;
		end
	end

	// ---- division row
	logic                div_valid [0:QB];
	ti2d_pkg::meta_t     div_meta  [0:QB];
	ti2d_pkg::div_flag_t div_flags [0:QB];
	logic [ZW-1:0]       div_ud    [0:QB];
	logic [RW-1:0]       div_rem_x [0:QB];
	logic [RW-1:0]       div_rem_y [0:QB];
	logic [QB-1:0]       div_q_x   [0:QB];
	logic [QB-1:0]       div_q_y   [0:QB];

	assign div_valid[0] = valid_s7;
	assign div_meta[0]  = meta_s7;
	assign div_flags[0] = flags_s7;
	assign div_ud[0]    = ud_s7;
	assign div_rem_x[0] = rem_x_s7;
	assign div_rem_y[0] = rem_y_s7;
	assign div_q_x[0]   = '0;
	assign div_q_y[0]   = '0;

	for (genvar i = 0; i < QB; i++) begin : g_div
		ti2d_div_cell #(.RW(RW), .ZW(ZW), .QB(QB), .K(QB - 1 - i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.in_valid  (div_valid[i]),
			.in_meta   (div_meta[i]),
			.in_flags  (div_flags[i]),
			.in_ud     (div_ud[i]),
			.in_rem_x  (div_rem_x[i]),
			.in_rem_y  (div_rem_y[i]),
			.in_q_x    (div_q_x[i]),
			.in_q_y    (div_q_y[i]),
			.out_valid (div_valid[i+1]),
			.out_meta  (div_meta[i+1]),
			.out_flags (div_flags[i+1]),
			.out_ud    (div_ud[i+1]),
			.out_rem_x (div_rem_x[i+1]),
			.out_rem_y (div_rem_y[i+1]),
			.out_q_x   (div_q_x[i+1]),
			.out_q_y   (div_q_y[i+1])
		);
	end

	// ---- output register: sign, clip, zero-rate bypass
	logic [WW:0]     lane_x_c, lane_y_c;
	ti2d_pkg::pose_t pose_c;
	ti2d_pkg::meta_t fin_meta;

	always_comb begin
		fin_meta = div_meta[QB];
		lane_x_c = lane_result(div_q_x[QB], div_flags[QB].neg_x, div_flags[QB].over_x);
		lane_y_c = lane_result(div_q_y[QB], div_flags[QB].neg_y, div_flags[QB].over_y);
		pose_c.pose_angle = fin_meta.twist.angular_rate;
		if (fin_meta.twist.angular_rate == '0) begin
			pose_c.pose_x    = fin_meta.twist.rate_x;
			pose_c.pose_y    = fin_meta.twist.rate_y;
			pose_c.saturated = 1'b0;
		end else begin
			pose_c.pose_x    = $signed(lane_x_c[WW-1:0]);
			pose_c.pose_y    = $signed(lane_y_c[WW-1:0]);
			pose_c.saturated = lane_x_c[WW] | lane_y_c[WW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_valid <= 1'b0;
		end else if (adv) begin
			pose_valid <= div_valid[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pose <= pose_c;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ti2d_checker.sv =====
// ----------------------------------------------------------------------------
// ti2d_checker
// Port-level checks on the twist integrator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ti2d_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        twist_valid,
	input wire logic        twist_stall,
	input ti2d_pkg::twist_t twist,
	input wire logic        pose_valid,
	input wire logic        pose_stall,
	input ti2d_pkg::pose_t  pose
);

	`TI2D_ASSERT_NEXT(a_pose_hold, clk, arst_n, pose_valid && pose_stall, pose_valid, "pose beat dropped while stalled")
	`TI2D_ASSERT_NEXT(a_pose_stable, clk, arst_n, pose_valid && pose_stall, $stable(pose), "stalled pose beat changed")
	`TI2D_ASSERT(a_stall_cause, clk, arst_n, twist_stall == (pose_valid && pose_stall), "twist stall without a blocked pose beat")
	`TI2D_ASSERT(a_zero_no_sat, clk, arst_n, !(pose_valid && (pose.pose_angle == '0) && pose.saturated), "zero-rate beat flagged as saturated")

endmodule

bind twist_integrate_2d_core ti2d_checker u_ti2d_checker (.*);

`default_nettype wire
